>>> design/mavt_pkg.sv
package mavt_pkg;

   // tracker geometry
   localparam int TURN_BITS  = 16;
   localparam int ANGLE_BITS = 12;

   // item and result field widths
   localparam int OP_W      = 2;
   localparam int RAW_W     = 12;
   localparam int TIME_W    = 16;
   localparam int POS_W     = 28;
   localparam int VEL_W     = 32;
   localparam int EST_W     = 36;
   localparam int FAIL_W    = 16;
   localparam int FRAC_BITS = 8;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALE_LIMIT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LATENCY     = CSR_INDEX_W'(1);
   localparam logic [TIME_W-1:0] STALE_LIMIT_RESET = TIME_W'(1200);
   localparam logic [TIME_W-1:0] LATENCY_RESET     = TIME_W'(200);

   // serial arithmetic
   localparam int SPAN_W    = TIME_W + 1;
   localparam int MUL_A_W   = VEL_W;
   localparam int MUL_B_W   = 20;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W   = 56;
   localparam int DIV_D_W   = MUL_B_W;
   localparam int DIV_STEPS = DIV_N_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
   localparam int PROD_W    = DIV_N_W - FRAC_BITS;
   localparam logic [MUL_B_W-1:0] US_PER_S = MUL_B_W'(1000000);

   // position before saturation, estimate before saturation
   localparam int POS_EXT_W  = (TURN_BITS + ANGLE_BITS > POS_W) ? TURN_BITS + ANGLE_BITS : POS_W;
   localparam int EST_CALC_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_START    = 2'd0,
      OP_UPDATE   = 2'd1,
      OP_ESTIMATE = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

>>> design/mavt_if.sv
interface mavt_req_if;
   logic                          valid;
   logic                          ready;
   logic [mavt_pkg::OP_W-1:0]     operation;
   logic [mavt_pkg::RAW_W-1:0]    raw_angle;
   logic                          read_ok;
   logic [mavt_pkg::TIME_W-1:0]   time_us;

   modport source (output valid, operation, raw_angle, read_ok, time_us, input ready);
   modport sink (input valid, operation, raw_angle, read_ok, time_us, output ready);
endinterface

interface mavt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [mavt_pkg::POS_W-1:0]  position_counts;
   logic signed [mavt_pkg::VEL_W-1:0]  velocity_cps;
   logic signed [mavt_pkg::EST_W-1:0]  estimate_q8;
   logic                               not_responding;
   logic                               status_error;
   logic [mavt_pkg::FAIL_W-1:0]        fail_count;

   modport source (output valid, position_counts, velocity_cps, estimate_q8, not_responding,
                   status_error, fail_count, input ready);
   modport sink (input valid, position_counts, velocity_cps, estimate_q8, not_responding,
                 status_error, fail_count, output ready);
endinterface

interface mavt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mavt_pkg::CSR_INDEX_W-1:0]   index;
   logic [mavt_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/mavt_mul.sv
module mavt_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mavt_pkg::MUL_A_W-1:0]     a,
   input  logic [mavt_pkg::MUL_B_W-1:0]     b,
   output mavt_pkg::unit_status_type        status,
   output logic [mavt_pkg::MUL_P_W-1:0]     product
);

   logic                          run_ff, run_in;
   logic [mavt_pkg::MUL_P_W-1:0]  a_ff, a_in;
   logic [mavt_pkg::MUL_P_W-1:0]  acc_ff, acc_in;
   logic [mavt_pkg::MUL_B_W-1:0]  b_ff, b_in;

   // shift-add, one multiplier bit per cycle, stops once no set bits remain
   always_comb begin
      run_in = run_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      if (start) begin
         run_in = 1'b1;
         a_in   = mavt_pkg::MUL_P_W'(a);
         b_in   = b;
         acc_in = '0;
      end else if (run_ff) begin
         if (b_ff == '0) begin
            run_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   assign status.busy = run_ff;
   assign status.done = run_ff && (b_ff == '0);
   assign product     = acc_ff;

endmodule

>>> design/mavt_div.sv
module mavt_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mavt_pkg::DIV_N_W-1:0]     dividend,
   input  logic [mavt_pkg::DIV_D_W-1:0]     divisor,
   output mavt_pkg::unit_status_type        status,
   output logic [mavt_pkg::DIV_N_W-1:0]     quotient
);

   localparam int NW = mavt_pkg::DIV_N_W;
   localparam int DW = mavt_pkg::DIV_D_W;

   logic                            run_ff, run_in;
   logic [mavt_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]                   rem_ff, rem_in;
   logic [DW-1:0]                   d_ff, d_in;
   logic [NW-1:0]                   num_ff, num_in;

   logic [DW:0] r1, r1s, r2, r2s;
   logic        q1, q2;

   // two restoring steps per cycle, quotient bits shift in where dividend bits leave
   assign r1  = {rem_ff, num_ff[NW-1]};
   assign q1  = r1 >= {1'b0, d_ff};
   assign r1s = q1 ? r1 - {1'b0, d_ff} : r1;
   assign r2  = {r1s[DW-1:0], num_ff[NW-2]};
   assign q2  = r2 >= {1'b0, d_ff};
   assign r2s = q2 ? r2 - {1'b0, d_ff} : r2;

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      d_in   = d_ff;
      num_in = num_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = mavt_pkg::DIV_CNT_W'(mavt_pkg::DIV_STEPS);
         rem_in = '0;
         d_in   = divisor;
         num_in = dividend;
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            run_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - mavt_pkg::DIV_CNT_W'(1);
            rem_in = r2s[DW-1:0];
            num_in = {num_ff[NW-3:0], q1, q2};
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      num_ff <= num_in;
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   assign status.busy = run_ff;
   assign status.done = run_ff && (cnt_ff == '0);
   assign quotient    = num_ff;

endmodule

>>> design/multiturn_angle_velocity_tracker.sv
// Multiturn tracker for a 4096-count absolute encoder. Each item is a start, an update or an
// estimate query, stamped with a free-running microsecond timer; every item returns exactly
// one result carrying position, velocity, estimate and status. Start, no-operation, stale
// estimate and zero-elapsed update items go from preparation straight to the result. Other
// updates and estimates pass through the bit-serial multiplier (times one million, or times
// elapsed-plus-latency) and then the divider, which retires two quotient bits a cycle over a
// 56-bit dividend. One item is worked on at a time; the next item is taken while an earlier
// result still waits on the output register. The user must write configuration through the
// csr channel only while no item is in progress; the block itself does not enforce this.
module multiturn_angle_velocity_tracker (
   input  logic        clock,
   input  logic        reset,
   mavt_req_if.sink    req_ch,
   mavt_rsp_if.source  rsp_ch,
   mavt_csr_if.sink    csr_ch
);

   localparam int AB  = mavt_pkg::ANGLE_BITS;
   localparam int TB  = mavt_pkg::TURN_BITS;
   localparam int PW  = mavt_pkg::POS_W;
   localparam int VW  = mavt_pkg::VEL_W;
   localparam int EW  = mavt_pkg::EST_W;
   localparam int ECW = mavt_pkg::EST_CALC_W;
   localparam int TW  = mavt_pkg::TIME_W;

   localparam logic signed [TB-1:0] TURN_MAX = {1'b0, {(TB-1){1'b1}}};
   localparam logic signed [TB-1:0] TURN_MIN = {1'b1, {(TB-1){1'b0}}};
   localparam logic signed [PW-1:0] POS_MAX  = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] POS_MIN  = {1'b1, {(PW-1){1'b0}}};
   localparam logic signed [VW-1:0] VEL_MAX  = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VEL_MIN  = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [EW-1:0] EST_MAX  = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0] EST_MIN  = {1'b1, {(EW-1){1'b0}}};
   localparam logic [mavt_pkg::DIV_N_W-1:0] VEL_POS_LIM =
      mavt_pkg::DIV_N_W'({1'b0, {(VW-1){1'b1}}});
   localparam logic [mavt_pkg::DIV_N_W-1:0] VEL_NEG_LIM =
      mavt_pkg::DIV_N_W'({1'b1, {(VW-1){1'b0}}});
   localparam logic [AB+2:0] WRAP_LIM = {3'b100, {AB{1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // accepted item
   mavt_pkg::op_type   op_ff, op_in;
   logic [AB-1:0]      raw_ff, raw_in;
   logic               ok_ff, ok_in;
   logic [TW-1:0]      now_ff, now_in;

   // tracker state and configuration
   logic [AB-1:0]                   last_raw_ff, last_raw_in;
   logic signed [TB-1:0]            turn_ff, turn_in;
   logic signed [PW-1:0]            pos_ff, pos_in;
   logic signed [VW-1:0]            vel_ff, vel_in;
   logic [TW-1:0]                   last_time_ff, last_time_in;
   logic                            stale_ff, stale_in;
   logic                            err_ff, err_in;
   logic [mavt_pkg::FAIL_W-1:0]     fail_ff, fail_in;
   logic [TW-1:0]                   stale_limit_ff, stale_limit_in;
   logic [TW-1:0]                   latency_ff, latency_in;

   // working registers
   logic                            neg_ff, neg_in;
   logic [mavt_pkg::DIV_D_W-1:0]    div_d_ff, div_d_in;
   logic signed [EW-1:0]            est_ff, est_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [PW-1:0]            out_pos_ff, out_pos_in;
   logic signed [VW-1:0]            out_vel_ff, out_vel_in;
   logic signed [EW-1:0]            out_est_ff, out_est_in;
   logic                            out_stale_ff, out_stale_in;
   logic                            out_err_ff, out_err_in;
   logic [mavt_pkg::FAIL_W-1:0]     out_fail_ff, out_fail_in;

   // datapath
   logic [TW-1:0]                   dt;
   logic [mavt_pkg::SPAN_W-1:0]     span;
   logic                            stale;
   logic signed [AB:0]              d_ang;
   logic [AB-1:0]                   ad;
   logic [AB+2:0]                   ad5;
   logic                            wrap;
   logic signed [TB-1:0]            turn_next;
   logic signed [mavt_pkg::POS_EXT_W-1:0] pos_ext;
   logic                            pos_fits;
   logic signed [PW-1:0]            np;
   logic signed [PW:0]              dp;
   logic [PW-1:0]                   dp_mag;
   logic [VW-1:0]                   vel_mag;
   logic                            go_mul;

   logic                            mul_start;
   logic [mavt_pkg::MUL_A_W-1:0]    mul_a;
   logic [mavt_pkg::MUL_B_W-1:0]    mul_b;
   logic [mavt_pkg::MUL_P_W-1:0]    mul_p;
   mavt_pkg::unit_status_type       mul_st;

   logic                            div_start;
   logic [mavt_pkg::DIV_N_W-1:0]    div_n;
   logic [mavt_pkg::DIV_N_W-1:0]    quo;
   mavt_pkg::unit_status_type       div_st;

   logic signed [VW-1:0]            vel_sat;
   logic signed [ECW-1:0]           est_term, est_base, est_sum;
   logic                            est_fits;
   logic signed [EW-1:0]            est_sat;

   // equal or earlier timer value counts as a rollover: a full wrap plus the difference, less one
   assign dt = (now_ff > last_time_ff) ? now_ff - last_time_ff
                                       : now_ff - last_time_ff - TW'(1);
   assign span  = mavt_pkg::SPAN_W'(dt) + mavt_pkg::SPAN_W'(latency_ff);
   assign stale = dt > stale_limit_ff;

   assign d_ang = signed'({1'b0, raw_ff}) - signed'({1'b0, last_raw_ff});
   assign ad    = d_ang[AB] ? AB'(-d_ang) : d_ang[AB-1:0];
   assign ad5   = (AB+3)'(ad) + ((AB+3)'(ad) << 2);
   assign wrap  = ad5 > WRAP_LIM;

   always_comb begin
      turn_next = turn_ff;
      if (wrap) begin
         if (!d_ang[AB]) begin
            if (turn_ff != TURN_MIN) begin
               turn_next = turn_ff - TB'(1);
            end
         end else if (turn_ff != TURN_MAX) begin
            turn_next = turn_ff + TB'(1);
         end
      end
   end

   // turn count times counts per turn plus angle is the concatenation
   assign pos_ext  = mavt_pkg::POS_EXT_W'(signed'({turn_next, raw_ff}));
   assign pos_fits = (pos_ext[mavt_pkg::POS_EXT_W-1:PW-1] == '0) ||
                     (pos_ext[mavt_pkg::POS_EXT_W-1:PW-1] == '1);
   assign np       = pos_fits ? pos_ext[PW-1:0]
                              : (pos_ext[mavt_pkg::POS_EXT_W-1] ? POS_MIN : POS_MAX);
   assign dp       = {np[PW-1], np} - {pos_ff[PW-1], pos_ff};
   assign dp_mag   = dp[PW] ? PW'(-dp) : dp[PW-1:0];
   assign vel_mag  = vel_ff[VW-1] ? unsigned'(-vel_ff) : unsigned'(vel_ff);

   assign go_mul    = ((op_ff == mavt_pkg::OP_UPDATE) && (dt != '0)) ||
                      ((op_ff == mavt_pkg::OP_ESTIMATE) && !stale);
   assign mul_start = (state_ff == ST_PREP) && go_mul;
   assign mul_a     = (op_ff == mavt_pkg::OP_UPDATE) ? mavt_pkg::MUL_A_W'(dp_mag) : vel_mag;
   assign mul_b     = (op_ff == mavt_pkg::OP_UPDATE) ? mavt_pkg::US_PER_S
                                                     : mavt_pkg::MUL_B_W'(span);

   assign div_start = (state_ff == ST_MUL) && mul_st.done;
   assign div_n     = (op_ff == mavt_pkg::OP_UPDATE)
                      ? mavt_pkg::DIV_N_W'(mul_p[mavt_pkg::PROD_W-1:0])
                      : {mul_p[mavt_pkg::PROD_W-1:0], {mavt_pkg::FRAC_BITS{1'b0}}};

   mavt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .status  (mul_st),
      .product (mul_p)
   );

   mavt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d_ff),
      .status   (div_st),
      .quotient (quo)
   );

   // quotient magnitude back to signed values with saturation
   always_comb begin
      if (!neg_ff) begin
         vel_sat = (quo > VEL_POS_LIM) ? VEL_MAX : signed'(quo[VW-1:0]);
      end else begin
         vel_sat = (quo > VEL_NEG_LIM) ? VEL_MIN : -signed'(quo[VW-1:0]);
      end
   end

   assign est_term = neg_ff ? -signed'(quo[ECW-1:0]) : signed'(quo[ECW-1:0]);
   assign est_base = signed'({{(ECW-PW-mavt_pkg::FRAC_BITS){pos_ff[PW-1]}}, pos_ff,
                              {mavt_pkg::FRAC_BITS{1'b0}}});
   assign est_sum  = est_base + est_term;
   assign est_fits = (est_sum[ECW-1:EW-1] == '0) || (est_sum[ECW-1:EW-1] == '1);
   assign est_sat  = est_fits ? est_sum[EW-1:0] : (est_sum[ECW-1] ? EST_MIN : EST_MAX);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      raw_in         = raw_ff;
      ok_in          = ok_ff;
      now_in         = now_ff;
      last_raw_in    = last_raw_ff;
      turn_in        = turn_ff;
      pos_in         = pos_ff;
      vel_in         = vel_ff;
      last_time_in   = last_time_ff;
      stale_in       = stale_ff;
      err_in         = err_ff;
      fail_in        = fail_ff;
      stale_limit_in = stale_limit_ff;
      latency_in     = latency_ff;
      neg_in         = neg_ff;
      div_d_in       = div_d_ff;
      est_in         = est_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_pos_in     = out_pos_ff;
      out_vel_in     = out_vel_ff;
      out_est_in     = out_est_ff;
      out_stale_in   = out_stale_ff;
      out_err_in     = out_err_ff;
      out_fail_in    = out_fail_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_ch.valid) begin
         case (csr_ch.index)
            mavt_pkg::CSR_STALE_LIMIT: stale_limit_in = TW'(csr_ch.data);
            mavt_pkg::CSR_LATENCY:     latency_in     = TW'(csr_ch.data);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = mavt_pkg::op_type'(req_ch.operation);
               raw_in   = req_ch.raw_angle[AB-1:0];
               ok_in    = req_ch.read_ok;
               now_in   = req_ch.time_us;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            est_in   = '0;
            state_in = ST_DONE;
            case (op_ff)
               mavt_pkg::OP_START: begin
                  last_raw_in  = raw_ff;
                  turn_in      = '0;
                  pos_in       = '0;
                  vel_in       = '0;
                  last_time_in = now_ff;
               end
               mavt_pkg::OP_UPDATE: begin
                  if (!ok_ff) begin
                     err_in  = 1'b1;
                     fail_in = fail_ff + mavt_pkg::FAIL_W'(1);
                  end
                  turn_in      = turn_next;
                  last_raw_in  = raw_ff;
                  pos_in       = np;
                  last_time_in = now_ff;
                  neg_in       = dp[PW];
                  div_d_in     = mavt_pkg::DIV_D_W'(dt);
                  if (dt == '0) begin
                     // no elapsed time: only the direction survives
                     if (dp == '0) begin
                        vel_in = '0;
                     end else begin
                        vel_in = dp[PW] ? VEL_MIN : VEL_MAX;
                     end
                  end else begin
                     state_in = ST_MUL;
                  end
               end
               mavt_pkg::OP_ESTIMATE: begin
                  if (stale) begin
                     stale_in = 1'b1;
                  end else begin
                     stale_in = 1'b0;
                     neg_in   = vel_ff[VW-1];
                     div_d_in = mavt_pkg::US_PER_S;
                     state_in = ST_MUL;
                  end
               end
               default: ;
            endcase
         end
         ST_MUL: begin
            if (mul_st.done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               if (op_ff == mavt_pkg::OP_UPDATE) begin
                  vel_in = vel_sat;
               end else begin
                  est_in = est_sat;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_pos_in   = pos_ff;
               out_vel_in   = vel_ff;
               out_est_in   = est_ff;
               out_stale_in = stale_ff;
               out_err_in   = err_ff;
               out_fail_in  = fail_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      raw_ff      <= raw_in;
      ok_ff       <= ok_in;
      now_ff      <= now_in;
      neg_ff      <= neg_in;
      div_d_ff    <= div_d_in;
      est_ff      <= est_in;
      out_pos_ff  <= out_pos_in;
      out_vel_ff  <= out_vel_in;
      out_est_ff  <= out_est_in;
      out_stale_ff <= out_stale_in;
      out_err_ff  <= out_err_in;
      out_fail_ff <= out_fail_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         last_raw_ff    <= '0;
         turn_ff        <= '0;
         pos_ff         <= '0;
         vel_ff         <= '0;
         last_time_ff   <= '0;
         stale_ff       <= 1'b0;
         err_ff         <= 1'b0;
         fail_ff        <= '0;
         stale_limit_ff <= mavt_pkg::STALE_LIMIT_RESET;
         latency_ff     <= mavt_pkg::LATENCY_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_raw_ff    <= last_raw_in;
         turn_ff        <= turn_in;
         pos_ff         <= pos_in;
         vel_ff         <= vel_in;
         last_time_ff   <= last_time_in;
         stale_ff       <= stale_in;
         err_ff         <= err_in;
         fail_ff        <= fail_in;
         stale_limit_ff <= stale_limit_in;
         latency_ff     <= latency_in;
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE) && !reset;
   assign csr_ch.ready          = !reset;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.position_counts = out_pos_ff;
   assign rsp_ch.velocity_cps   = out_vel_ff;
   assign rsp_ch.estimate_q8    = out_est_ff;
   assign rsp_ch.not_responding = out_stale_ff;
   assign rsp_ch.status_error   = out_err_ff;
   assign rsp_ch.fail_count     = out_fail_ff;

`ifndef SYNTHESIS
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_st.busy && div_st.busy))
      else $error("multiplier and divider busy together");

   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_PREP))
      else $error("accepted item did not enter preparation");

   a_stale_zero_estimate: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.not_responding) |-> (rsp_ch.estimate_q8 == '0))
      else $error("stale result carries a nonzero estimate");

   a_fail_sets_error: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (fail_ff != $past(fail_ff))) |-> err_ff)
      else $error("failure count moved without the error flag");
`endif

endmodule

>>> test/testbench.sv
module testbench;

   localparam longint CPR          = longint'(1) << mavt_pkg::ANGLE_BITS;
   localparam longint TURN_HI      = (longint'(1) << (mavt_pkg::TURN_BITS - 1)) - 1;
   localparam longint TURN_LO      = -(longint'(1) << (mavt_pkg::TURN_BITS - 1));
   localparam longint POS_HI       = (longint'(1) << (mavt_pkg::POS_W - 1)) - 1;
   localparam longint POS_LO       = -(longint'(1) << (mavt_pkg::POS_W - 1));
   localparam longint VEL_HI       = (longint'(1) << (mavt_pkg::VEL_W - 1)) - 1;
   localparam longint VEL_LO       = -(longint'(1) << (mavt_pkg::VEL_W - 1));
   localparam longint EST_HI       = (longint'(1) << (mavt_pkg::EST_W - 1)) - 1;
   localparam longint EST_LO       = -(longint'(1) << (mavt_pkg::EST_W - 1));
   localparam longint Q_ONE        = longint'(1) << mavt_pkg::FRAC_BITS;
   localparam longint MICROS_PER_S = 1000000;
   localparam int     TIMER_TOP    = (1 << mavt_pkg::TIME_W) - 1;
   localparam int     PHASE_ITEMS  = 300;
   localparam int     QUIET_AFTER  = 50;
   localparam int     SETTLE_CYCLES = 60;

   typedef struct packed {
      mavt_pkg::op_type                 op;
      logic [mavt_pkg::RAW_W-1:0]       raw;
      logic                             ok;
      logic [mavt_pkg::TIME_W-1:0]      stamp;
   } sample_item_type;

   typedef struct packed {
      logic signed [mavt_pkg::POS_W-1:0] position;
      logic signed [mavt_pkg::VEL_W-1:0] velocity;
      logic signed [mavt_pkg::EST_W-1:0] estimate;
      logic                              stale;
      logic                              read_error;
      logic [mavt_pkg::FAIL_W-1:0]       failures;
   } tracker_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mavt_req_if req_ch ();
   mavt_rsp_if rsp_ch ();
   mavt_csr_if csr_ch ();

   multiturn_angle_velocity_tracker uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // predicted tracker state and its register copies
   logic [mavt_pkg::RAW_W-1:0]  trk_last_raw;
   longint                      trk_turns;
   longint                      trk_position;
   longint                      trk_velocity;
   int                          trk_last_time;
   logic                        trk_stale;
   logic                        trk_read_error;
   logic [mavt_pkg::FAIL_W-1:0] trk_failures;
   int                          lim_stale_us;
   int                          lim_latency_us;

   tracker_report_type          expected_reports [$];

   int                          mismatches;
   int                          results_seen;
   int                          csr_writes;
   int                          op_count [4];
   int                          idle_pct;
   int                          stall_pct;

   // stimulus cursors for the random motion
   logic [mavt_pkg::TIME_W-1:0] gen_time;
   logic [mavt_pkg::RAW_W-1:0]  gen_angle;

   function automatic longint clamp_long(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // an equal or earlier stamp counts as a timer rollover
   function automatic int elapsed_since(input int now);
      if (now <= trk_last_time) return TIMER_TOP - trk_last_time + now;
      return now - trk_last_time;
   endfunction

   function automatic tracker_report_type track_item(input sample_item_type it);
      tracker_report_type r;
      int                 now;
      int                 dt;
      longint             d;
      longint             ad;
      longint             np;
      longint             dp;
      longint             span;
      longint             term;
      longint             est;
      now = int'(it.stamp);
      est = 0;
      case (it.op)
         mavt_pkg::OP_START: begin
            trk_last_raw  = it.raw;
            trk_turns     = 0;
            trk_position  = 0;
            trk_velocity  = 0;
            trk_last_time = now;
         end
         mavt_pkg::OP_UPDATE: begin
            dt = elapsed_since(now);
            d  = longint'(it.raw) - longint'(trk_last_raw);
            ad = (d < 0) ? -d : d;
            if (!it.ok) begin
               trk_read_error = 1'b1;
               trk_failures   = trk_failures + mavt_pkg::FAIL_W'(1);
            end
            // a jump of more than 0.8 turn is taken as crossing zero
            if (ad * 5 > CPR * 4)
               trk_turns = clamp_long(trk_turns + ((d > 0) ? longint'(-1) : longint'(1)),
                                      TURN_LO, TURN_HI);
            trk_last_raw = it.raw;
            np = clamp_long(trk_turns * CPR + longint'(it.raw), POS_LO, POS_HI);
            dp = np - trk_position;
            if (dt == 0)
               trk_velocity = (dp > 0) ? VEL_HI : ((dp < 0) ? VEL_LO : longint'(0));
            else
               trk_velocity = clamp_long(dp * MICROS_PER_S / longint'(dt), VEL_LO, VEL_HI);
            trk_position  = np;
            trk_last_time = now;
         end
         mavt_pkg::OP_ESTIMATE: begin
            dt = elapsed_since(now);
            if (dt > lim_stale_us) begin
               trk_stale = 1'b1;
            end else begin
               span      = longint'(dt) + longint'(lim_latency_us);
               term      = trk_velocity * span * Q_ONE / MICROS_PER_S;
               trk_stale = 1'b0;
               est       = clamp_long(trk_position * Q_ONE + term, EST_LO, EST_HI);
            end
         end
         default: ;
      endcase
      r.position   = mavt_pkg::POS_W'(trk_position);
      r.velocity   = mavt_pkg::VEL_W'(trk_velocity);
      r.estimate   = mavt_pkg::EST_W'(est);
      r.stale      = trk_stale;
      r.read_error = trk_read_error;
      r.failures   = trk_failures;
      return r;
   endfunction

   task automatic reset_tracker_model();
      trk_last_raw   = '0;
      trk_turns      = 0;
      trk_position   = 0;
      trk_velocity   = 0;
      trk_last_time  = 0;
      trk_stale      = 1'b0;
      trk_read_error = 1'b0;
      trk_failures   = '0;
      lim_stale_us   = int'(mavt_pkg::STALE_LIMIT_RESET);
      lim_latency_us = int'(mavt_pkg::LATENCY_RESET);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      // quiet after the first 50 mismatches so a dead block does not flood the log
      if (mismatches <= QUIET_AFTER)
         $display("%0t result %0d: %s got %0d expected %0d", $time, results_seen, what, got,
                  want);
   endtask

   task automatic check_report();
      tracker_report_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch("unexpected result, position_counts",
                         longint'(rsp_ch.position_counts), longint'(0));
         return;
      end
      want = expected_reports.pop_front();
      if (rsp_ch.position_counts !== want.position)
         report_mismatch("position_counts", longint'(rsp_ch.position_counts),
                         longint'(want.position));
      if (rsp_ch.velocity_cps !== want.velocity)
         report_mismatch("velocity_cps", longint'(rsp_ch.velocity_cps),
                         longint'(want.velocity));
      if (rsp_ch.estimate_q8 !== want.estimate)
         report_mismatch("estimate_q8", longint'(rsp_ch.estimate_q8),
                         longint'(want.estimate));
      if (rsp_ch.not_responding !== want.stale)
         report_mismatch("not_responding", longint'(rsp_ch.not_responding),
                         longint'(want.stale));
      if (rsp_ch.status_error !== want.read_error)
         report_mismatch("status_error", longint'(rsp_ch.status_error),
                         longint'(want.read_error));
      if (rsp_ch.fail_count !== want.failures)
         report_mismatch("fail_count", longint'(rsp_ch.fail_count),
                         longint'(want.failures));
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_report();
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(input sample_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= it.op;
      req_ch.raw_angle <= it.raw;
      req_ch.read_ok   <= it.ok;
      req_ch.time_us   <= it.stamp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_reports.push_back(track_item(it));
      op_count[it.op]++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   // writes both registers back to back once the tracker is idle
   task automatic configure(input int stale_us, input int latency_us);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= mavt_pkg::CSR_STALE_LIMIT;
      csr_ch.data  <= mavt_pkg::CSR_DATA_W'(stale_us);
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      lim_stale_us = stale_us;
      csr_ch.index <= mavt_pkg::CSR_LATENCY;
      csr_ch.data  <= mavt_pkg::CSR_DATA_W'(latency_us);
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      lim_latency_us = latency_us;
      csr_ch.valid <= 1'b0;
      csr_writes += 2;
   endtask

   function automatic sample_item_type item_of(input mavt_pkg::op_type op, input int raw,
                                               input bit ok, input int stamp);
      sample_item_type it;
      it.op    = op;
      it.raw   = mavt_pkg::RAW_W'(raw);
      it.ok    = ok;
      it.stamp = mavt_pkg::TIME_W'(stamp);
      return it;
   endfunction

   function automatic logic [mavt_pkg::TIME_W-1:0] next_stamp(input int reach);
      int roll;
      roll = int'($urandom_range(99));
      if (gen_time == '1 && roll < 50)
         gen_time = '0;            // zero elapsed time across the rollover
      else if (roll < 4)
         ;                         // same stamp again, counted as a full timer period less one
      else if (roll < 8)
         gen_time = '1;
      else
         gen_time = mavt_pkg::TIME_W'(int'(gen_time) + int'($urandom_range(1, reach)));
      return gen_time;
   endfunction

   task automatic run_motion(input int count);
      sample_item_type it;
      int              pick;
      int              reach;
      reach = lim_stale_us + lim_stale_us / 2;
      if (reach < 64) reach = 64;
      if (reach > TIMER_TOP) reach = TIMER_TOP;
      for (int n = 0; n < count; n++) begin
         pick     = int'($urandom_range(99));
         it.ok    = ($urandom_range(19) != 0);
         it.raw   = mavt_pkg::RAW_W'($urandom);
         it.stamp = mavt_pkg::TIME_W'($urandom);
         if (pick < 4) begin
            it.op     = mavt_pkg::OP_START;
            gen_angle = it.raw;
            it.stamp  = next_stamp(reach);
         end else if (pick < 62) begin
            it.op = mavt_pkg::OP_UPDATE;
            if ($urandom_range(9) == 0)
               gen_angle = mavt_pkg::RAW_W'($urandom);
            else
               gen_angle = mavt_pkg::RAW_W'(int'(gen_angle) + int'($urandom_range(0, 1600))
                                            - 800);
            it.raw   = gen_angle;
            // short gaps now and then push the velocity into saturation
            it.stamp = next_stamp(($urandom_range(9) == 0) ? 4 : reach);
         end else if (pick < 88) begin
            it.op    = mavt_pkg::OP_ESTIMATE;
            it.stamp = next_stamp(reach);
         end else if (pick < 93) begin
            it.op = mavt_pkg::OP_NOP;
         end else begin
            it.op     = mavt_pkg::OP_UPDATE;
            gen_angle = it.raw;
            gen_time  = it.stamp;
         end
         send_item(it);
      end
   endtask

   task automatic test_directed_cases();
      send_item(item_of(mavt_pkg::OP_START,    0,    1, 100));
      send_item(item_of(mavt_pkg::OP_UPDATE,   4095, 1, 65535));  // wraps down a turn
      send_item(item_of(mavt_pkg::OP_UPDATE,   0,    1, 0));      // zero elapsed, position rose
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 4095, 0, 1));
      send_item(item_of(mavt_pkg::OP_UPDATE,   100,  1, 65535));
      send_item(item_of(mavt_pkg::OP_UPDATE,   50,   1, 0));      // zero elapsed, position fell
      send_item(item_of(mavt_pkg::OP_UPDATE,   50,   1, 65535));
      send_item(item_of(mavt_pkg::OP_UPDATE,   50,   1, 0));      // zero elapsed, no motion
      send_item(item_of(mavt_pkg::OP_UPDATE,   3000, 1, 1));      // velocity clips high
      send_item(item_of(mavt_pkg::OP_UPDATE,   0,    1, 2));      // velocity clips low
      send_item(item_of(mavt_pkg::OP_UPDATE,   4095, 0, 10));     // failed read, still used
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 0,    1, 10));     // equal stamp is stale
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 0,    1, 500));    // fresh again
      send_item(item_of(mavt_pkg::OP_NOP,      4095, 0, 65535));
      send_item(item_of(mavt_pkg::OP_START,    4095, 0, 65535));  // flags survive a restart
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 0,    1, 0));
      send_item(item_of(mavt_pkg::OP_UPDATE,   819,  1, 300));    // just short of a wrap
      send_item(item_of(mavt_pkg::OP_UPDATE,   4095, 1, 400));
      send_item(item_of(mavt_pkg::OP_UPDATE,   818,  1, 500));    // just past a wrap
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 2048, 1, 600));
      send_item(item_of(mavt_pkg::OP_UPDATE,   4095, 1, 700));
   endtask

   task automatic test_register_extremes();
      configure(0, 0);
      send_item(item_of(mavt_pkg::OP_START,    100, 1, 1000));
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 0,   1, 1000));
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 0,   1, 1001));
      send_item(item_of(mavt_pkg::OP_UPDATE,   200, 1, 65535));
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 0,   1, 0));
      configure(TIMER_TOP, TIMER_TOP);
      send_item(item_of(mavt_pkg::OP_START,    0,    1, 10));
      send_item(item_of(mavt_pkg::OP_UPDATE,   3000, 1, 11));
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 0,    1, 10));     // estimate clips high
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 0,    1, 11));
      send_item(item_of(mavt_pkg::OP_UPDATE,   0,    1, 12));
      send_item(item_of(mavt_pkg::OP_ESTIMATE, 0,    1, 11));     // estimate clips low
   endtask

   task automatic test_random_motion();
      configure(int'($urandom_range(400, 4000)), int'($urandom_range(0, TIMER_TOP)));
      run_motion(PHASE_ITEMS);
      configure(TIMER_TOP, TIMER_TOP);
      run_motion(PHASE_ITEMS);
      configure(int'($urandom_range(0, TIMER_TOP)), int'($urandom_range(0, 2000)));
      run_motion(PHASE_ITEMS);
      configure(0, 0);
      run_motion(PHASE_ITEMS);
      // back to back traffic on both sides
      idle_pct  = 0;
      stall_pct = 0;
      configure(int'($urandom_range(200, 3000)), int'($urandom_range(0, 1000)));
      run_motion(PHASE_ITEMS);
      idle_pct  = 25;
      stall_pct = 25;
      configure(int'(mavt_pkg::STALE_LIMIT_RESET), int'(mavt_pkg::LATENCY_RESET));
      run_motion(PHASE_ITEMS);
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.operation = mavt_pkg::OP_NOP;
      req_ch.raw_angle = '0;
      req_ch.read_ok   = 1'b0;
      req_ch.time_us   = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = mavt_pkg::CSR_STALE_LIMIT;
      csr_ch.data      = '0;
      reset_tracker_model();
      mismatches   = 0;
      results_seen = 0;
      csr_writes   = 0;
      foreach (op_count[i]) op_count[i] = 0;
      idle_pct  = 25;
      stall_pct = 25;
      gen_time  = '0;
      gen_angle = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_random_motion();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d starts, %0d updates, %0d queries and %0d no-ops",
               op_count[mavt_pkg::OP_START], op_count[mavt_pkg::OP_UPDATE],
               op_count[mavt_pkg::OP_ESTIMATE], op_count[mavt_pkg::OP_NOP]);
      $display("%0d results compared field by field, %0d register writes, %0d mismatches",
               results_seen, csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // limit on the whole run
   initial begin
      #40_000_000;
      $display("timeout with %0d results still outstanding", expected_reports.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
design/mavt_pkg.sv
design/mavt_if.sv
design/mavt_mul.sv
design/mavt_div.sv
design/multiturn_angle_velocity_tracker.sv
test/testbench.sv
